/* rtl/core/ibcs_pkg.sv */
`timescale 1ns / 1ps

package ibcs_pkg;

  // Calibration round length and derived widths
  localparam int CAL_SAMPLES = 100;
  localparam int NUM_AXES    = 6;
  localparam int RAW_W       = 16;
  localparam int SUM_W       = RAW_W + $clog2(CAL_SAMPLES);
  localparam int CNT_W       = $clog2(CAL_SAMPLES + 1);
  localparam int NUM_W       = SUM_W + 8;
  localparam int Q_W         = 24;
  localparam int OFF_W       = 25;
  localparam int Q8_W        = 26;
  localparam int GAIN_W      = 24;
  localparam int BIAS_W      = 32;
  localparam int ONEG_W      = 15;
  localparam int OUT_W       = 32;
  localparam int SAT_W       = 40;
  localparam int DIV_STAGES  = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_GAIN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_GAIN   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_GAIN   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_BIAS   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_G_COUNT = CFG_IDX_W'(4);

  // Register reset values
  localparam logic [GAIN_W-1:0]        ACCEL_GAIN_RST = GAIN_W'(1024);
  localparam logic [GAIN_W-1:0]        GYRO_GAIN_RST  = GAIN_W'(128000);
  localparam logic [GAIN_W-1:0]        TEMP_GAIN_RST  = GAIN_W'(49345);
  localparam logic signed [BIAS_W-1:0] TEMP_BIAS_RST  = BIAS_W'(2394030);
  localparam logic [ONEG_W-1:0]        ONE_G_RST      = ONEG_W'(16384);

  // Word opcodes
  localparam logic OP_CAL  = 1'b0;
  localparam logic OP_MEAS = 1'b1;

  // Reciprocal of the round length for the offset divide
  localparam logic [NUM_W:0]   DIV_RECIP = (NUM_W+1)'(((65'd1) << NUM_W) / CAL_SAMPLES);
  localparam logic [NUM_W-1:0] DIV_C     = NUM_W'(CAL_SAMPLES);

  // Saturation bounds
  localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(-64'sh0000_0000_8000_0000);

  typedef logic signed [OUT_W-1:0] res_t;

  typedef struct packed {
    logic                    op;
    logic signed [RAW_W-1:0] accel_x_raw;
    logic signed [RAW_W-1:0] accel_y_raw;
    logic signed [RAW_W-1:0] accel_z_raw;
    logic signed [RAW_W-1:0] temp_raw;
    logic signed [RAW_W-1:0] gyro_x_raw;
    logic signed [RAW_W-1:0] gyro_y_raw;
    logic signed [RAW_W-1:0] gyro_z_raw;
  } in_word_t;

  typedef struct packed {
    res_t accel_x_out;
    res_t accel_y_out;
    res_t accel_z_out;
    res_t temp_out_q;
    res_t gyro_x_out;
    res_t gyro_y_out;
    res_t gyro_z_out;
    logic is_calibrated;
  } out_word_t;

  // Clamp a wide signed value to 32 bits
  function automatic res_t sat_out(input logic signed [SAT_W-1:0] v);
    res_t r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[OUT_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[OUT_W-1:0];
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/ibcs_in_if.sv */
`timescale 1ns / 1ps

interface ibcs_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    op;
  logic signed [ibcs_pkg::RAW_W-1:0]       accel_x_raw;
  logic signed [ibcs_pkg::RAW_W-1:0]       accel_y_raw;
  logic signed [ibcs_pkg::RAW_W-1:0]       accel_z_raw;
  logic signed [ibcs_pkg::RAW_W-1:0]       temp_raw;
  logic signed [ibcs_pkg::RAW_W-1:0]       gyro_x_raw;
  logic signed [ibcs_pkg::RAW_W-1:0]       gyro_y_raw;
  logic signed [ibcs_pkg::RAW_W-1:0]       gyro_z_raw;

  modport source (
    output valid, op, accel_x_raw, accel_y_raw, accel_z_raw, temp_raw,
           gyro_x_raw, gyro_y_raw, gyro_z_raw,
    input  ready
  );

  modport sink (
    input  valid, op, accel_x_raw, accel_y_raw, accel_z_raw, temp_raw,
           gyro_x_raw, gyro_y_raw, gyro_z_raw,
    output ready
  );
endinterface

/* rtl/core/ibcs_out_if.sv */
`timescale 1ns / 1ps

interface ibcs_out_if;
  logic           valid;
  logic           ready;
  ibcs_pkg::res_t accel_x_out;
  ibcs_pkg::res_t accel_y_out;
  ibcs_pkg::res_t accel_z_out;
  ibcs_pkg::res_t temp_out_q;
  ibcs_pkg::res_t gyro_x_out;
  ibcs_pkg::res_t gyro_y_out;
  ibcs_pkg::res_t gyro_z_out;
  logic           is_calibrated;

  modport source (
    output valid, accel_x_out, accel_y_out, accel_z_out, temp_out_q,
           gyro_x_out, gyro_y_out, gyro_z_out, is_calibrated,
    input  ready
  );

  modport sink (
    input  valid, accel_x_out, accel_y_out, accel_z_out, temp_out_q,
           gyro_x_out, gyro_y_out, gyro_z_out, is_calibrated,
    output ready
  );
endinterface

/* rtl/core/imu_bias_calibrate_and_scale_unit.sv */
`timescale 1ns / 1ps

// Channel  | Modport      | Word contents
// in_ch    | sink         | op, three accel axes, temperature, three gyro axes (16b signed)
// out_ch   | source       | six scaled axes and temperature (Q15.16), is_calibrated
// cfg_*    | write only   | gains, temperature bias, one-g counts by register index
//
// One word per cycle unless a divide runs or a stalled output holds a measurement word:
// input register, one multiply per lane, result register. The word that closes a
// calibration round stops the pipe while a four-stage reciprocal divide by CAL_SAMPLES
// forms the offsets. Synchronous active-low reset restores register defaults and clears
// offsets, sums, count and the calibrated flag. A stalled output holds its word while
// the input register still takes one more word.
module imu_bias_calibrate_and_scale_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  ibcs_in_if.sink                              in_ch,
  ibcs_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [ibcs_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [ibcs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // Configuration registers
  logic [ibcs_pkg::GAIN_W-1:0]        accel_gain_r;
  logic [ibcs_pkg::GAIN_W-1:0]        gyro_gain_r;
  logic [ibcs_pkg::GAIN_W-1:0]        temp_gain_r;
  logic signed [ibcs_pkg::BIAS_W-1:0] temp_bias_r;
  logic [ibcs_pkg::ONEG_W-1:0]        one_g_r;

  // Input stage
  ibcs_pkg::in_word_t in_word_r;
  logic               in_vld_r;
  logic               adv;
  logic               busy;
  logic               cal_fire;
  logic               cal_last;

  // Calibration state
  logic signed [ibcs_pkg::SUM_W-1:0] sums_r   [ibcs_pkg::NUM_AXES];
  logic signed [ibcs_pkg::SUM_W-1:0] sum_nxt  [ibcs_pkg::NUM_AXES];
  logic signed [ibcs_pkg::OFF_W-1:0] offset_r [ibcs_pkg::NUM_AXES];
  logic [ibcs_pkg::CNT_W-1:0]        cnt_r;
  logic                              cal_done_r;

  // Offset divide pipeline
  logic [ibcs_pkg::DIV_STAGES-1:0]   div_vld_r;
  logic signed [ibcs_pkg::SUM_W-1:0] snap_r    [ibcs_pkg::NUM_AXES];
  logic [ibcs_pkg::SUM_W-1:0]        mag_a_r   [ibcs_pkg::NUM_AXES];
  logic [ibcs_pkg::NUM_AXES-1:0]     neg_a_r;
  logic [ibcs_pkg::Q_W-1:0]          qest_b_r  [ibcs_pkg::NUM_AXES];
  logic [ibcs_pkg::NUM_W-1:0]        num_b_r   [ibcs_pkg::NUM_AXES];
  logic [ibcs_pkg::NUM_AXES-1:0]     neg_b_r;
  logic [ibcs_pkg::NUM_W-1:0]        qc_c_r    [ibcs_pkg::NUM_AXES];
  logic [ibcs_pkg::Q_W-1:0]          qest_c_r  [ibcs_pkg::NUM_AXES];
  logic [ibcs_pkg::NUM_W-1:0]        num_c_r   [ibcs_pkg::NUM_AXES];
  logic [ibcs_pkg::NUM_AXES-1:0]     neg_c_r;
  logic [ibcs_pkg::SUM_W-1:0]        mag_nxt   [ibcs_pkg::NUM_AXES];
  logic [ibcs_pkg::NUM_AXES-1:0]     neg_nxt;
  logic [ibcs_pkg::Q_W-1:0]          qest_nxt  [ibcs_pkg::NUM_AXES];
  logic signed [ibcs_pkg::OFF_W-1:0] off_nxt   [ibcs_pkg::NUM_AXES];

  // Scaling lanes
  logic signed [ibcs_pkg::RAW_W-1:0] axis_raw  [ibcs_pkg::NUM_AXES];
  ibcs_pkg::res_t                    axis_res  [ibcs_pkg::NUM_AXES];
  ibcs_pkg::res_t                    temp_res;

  // Output stage
  ibcs_pkg::out_word_t out_word_r;
  logic                out_vld_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_gain_r <= ibcs_pkg::ACCEL_GAIN_RST;
      gyro_gain_r  <= ibcs_pkg::GYRO_GAIN_RST;
      temp_gain_r  <= ibcs_pkg::TEMP_GAIN_RST;
      temp_bias_r  <= ibcs_pkg::TEMP_BIAS_RST;
      one_g_r      <= ibcs_pkg::ONE_G_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        ibcs_pkg::CFG_ACCEL_GAIN:  accel_gain_r <= cfg_wdata[ibcs_pkg::GAIN_W-1:0];
        ibcs_pkg::CFG_GYRO_GAIN:   gyro_gain_r  <= cfg_wdata[ibcs_pkg::GAIN_W-1:0];
        ibcs_pkg::CFG_TEMP_GAIN:   temp_gain_r  <= cfg_wdata[ibcs_pkg::GAIN_W-1:0];
        ibcs_pkg::CFG_TEMP_BIAS:   temp_bias_r  <= cfg_wdata[ibcs_pkg::BIAS_W-1:0];
        ibcs_pkg::CFG_ONE_G_COUNT: one_g_r      <= cfg_wdata[ibcs_pkg::ONEG_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the input word unless a divide runs or, for a measurement word, a result waits
  assign busy     = |div_vld_r;
  assign adv      = in_vld_r && !busy &&
                    (in_word_r.op == ibcs_pkg::OP_CAL || !out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || adv;
  assign cal_last = (cnt_r == ibcs_pkg::CNT_W'(ibcs_pkg::CAL_SAMPLES - 1));
  assign cal_fire = adv && (in_word_r.op == ibcs_pkg::OP_CAL) && cal_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_word_r.op          <= in_ch.op;
      in_word_r.accel_x_raw <= in_ch.accel_x_raw;
      in_word_r.accel_y_raw <= in_ch.accel_y_raw;
      in_word_r.accel_z_raw <= in_ch.accel_z_raw;
      in_word_r.temp_raw    <= in_ch.temp_raw;
      in_word_r.gyro_x_raw  <= in_ch.gyro_x_raw;
      in_word_r.gyro_y_raw  <= in_ch.gyro_y_raw;
      in_word_r.gyro_z_raw  <= in_ch.gyro_z_raw;
    end
  end

  // Lane order: accel x, y, z, gyro x, y, z
  assign axis_raw[0] = in_word_r.accel_x_raw;
  assign axis_raw[1] = in_word_r.accel_y_raw;
  assign axis_raw[2] = in_word_r.accel_z_raw;
  assign axis_raw[3] = in_word_r.gyro_x_raw;
  assign axis_raw[4] = in_word_r.gyro_y_raw;
  assign axis_raw[5] = in_word_r.gyro_z_raw;

  // Accumulate calibration words
  always_comb begin
    for (int i = 0; i < ibcs_pkg::NUM_AXES; i++) begin
      sum_nxt[i] = sums_r[i] + ibcs_pkg::SUM_W'(axis_raw[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ibcs_pkg::NUM_AXES; i++) begin
        sums_r[i] <= '0;
      end
      cnt_r      <= '0;
      cal_done_r <= 1'b0;
    end else if (adv && in_word_r.op == ibcs_pkg::OP_CAL) begin
      if (cal_last) begin
        for (int i = 0; i < ibcs_pkg::NUM_AXES; i++) begin
          sums_r[i] <= '0;
        end
        cnt_r      <= '0;
        cal_done_r <= 1'b1;
      end else begin
        for (int i = 0; i < ibcs_pkg::NUM_AXES; i++) begin
          sums_r[i] <= sum_nxt[i];
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Track the divide stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_vld_r <= '0;
    end else begin
      div_vld_r <= {div_vld_r[ibcs_pkg::DIV_STAGES-2:0], cal_fire};
    end
  end

  // Divide stage A: numerator sign and magnitude
  always_comb begin
    logic signed [ibcs_pkg::SUM_W:0] k_val;
    logic signed [ibcs_pkg::SUM_W:0] v;
    k_val = signed'((ibcs_pkg::SUM_W+1)'(one_g_r) *
                    (ibcs_pkg::SUM_W+1)'(ibcs_pkg::CAL_SAMPLES));
    for (int i = 0; i < ibcs_pkg::NUM_AXES; i++) begin
      if (i == 2) begin
        v = k_val - (ibcs_pkg::SUM_W+1)'(snap_r[i]);
      end else begin
        v = -((ibcs_pkg::SUM_W+1)'(snap_r[i]));
      end
      neg_nxt[i] = v[ibcs_pkg::SUM_W];
      mag_nxt[i] = neg_nxt[i] ? ibcs_pkg::SUM_W'(-v) : ibcs_pkg::SUM_W'(v);
    end
  end

  // Divide stage B: quotient estimate by reciprocal
  always_comb begin
    logic [ibcs_pkg::NUM_W-1:0] num;
    logic [2*ibcs_pkg::NUM_W:0] prod;
    for (int i = 0; i < ibcs_pkg::NUM_AXES; i++) begin
      num         = {mag_a_r[i], 8'b0};
      prod        = (2*ibcs_pkg::NUM_W+1)'(num) * (2*ibcs_pkg::NUM_W+1)'(ibcs_pkg::DIV_RECIP);
      qest_nxt[i] = prod[ibcs_pkg::NUM_W +: ibcs_pkg::Q_W];
    end
  end

  // Divide stage D: correct by one, restore sign
  always_comb begin
    logic [ibcs_pkg::NUM_W-1:0] rem;
    logic [ibcs_pkg::Q_W-1:0]   q;
    for (int i = 0; i < ibcs_pkg::NUM_AXES; i++) begin
      rem        = num_c_r[i] - qc_c_r[i];
      q          = qest_c_r[i] + ibcs_pkg::Q_W'(rem >= ibcs_pkg::DIV_C);
      off_nxt[i] = neg_c_r[i] ? -(ibcs_pkg::OFF_W'(q)) : ibcs_pkg::OFF_W'(q);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ibcs_pkg::NUM_AXES; i++) begin
      if (cal_fire) begin
        snap_r[i] <= sum_nxt[i];
      end
      mag_a_r[i]  <= mag_nxt[i];
      neg_a_r[i]  <= neg_nxt[i];
      qest_b_r[i] <= qest_nxt[i];
      num_b_r[i]  <= {mag_a_r[i], 8'b0};
      neg_b_r[i]  <= neg_a_r[i];
      qc_c_r[i]   <= ibcs_pkg::NUM_W'(qest_b_r[i]) * ibcs_pkg::DIV_C;
      qest_c_r[i] <= qest_b_r[i];
      num_c_r[i]  <= num_b_r[i];
      neg_c_r[i]  <= neg_b_r[i];
    end
  end

  // Load new offsets at the end of the divide
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ibcs_pkg::NUM_AXES; i++) begin
        offset_r[i] <= '0;
      end
    end else if (div_vld_r[ibcs_pkg::DIV_STAGES-1]) begin
      for (int i = 0; i < ibcs_pkg::NUM_AXES; i++) begin
        offset_r[i] <= off_nxt[i];
      end
    end
  end

  // Scale the motion axes
  always_comb begin
    logic signed [ibcs_pkg::Q8_W-1:0]     q8;
    logic signed [ibcs_pkg::GAIN_W:0]     gain_s;
    logic signed [ibcs_pkg::Q8_W+ibcs_pkg::GAIN_W:0] prod;
    for (int i = 0; i < ibcs_pkg::NUM_AXES; i++) begin
      q8     = (ibcs_pkg::Q8_W'(axis_raw[i]) <<< 8) + ibcs_pkg::Q8_W'(offset_r[i]);
      gain_s = (i < 3) ? signed'({1'b0, accel_gain_r}) : signed'({1'b0, gyro_gain_r});
      prod   = q8 * gain_s;
      axis_res[i] = ibcs_pkg::sat_out(
        ibcs_pkg::SAT_W'(signed'(prod[ibcs_pkg::Q8_W+ibcs_pkg::GAIN_W:16])));
    end
  end

  // Scale temperature and add its bias
  always_comb begin
    logic signed [ibcs_pkg::GAIN_W:0]              gain_s;
    logic signed [ibcs_pkg::RAW_W+ibcs_pkg::GAIN_W:0] prod;
    logic signed [ibcs_pkg::BIAS_W+1:0]            sum;
    gain_s   = signed'({1'b0, temp_gain_r});
    prod     = in_word_r.temp_raw * gain_s;
    sum      = (ibcs_pkg::BIAS_W+2)'(signed'(prod[ibcs_pkg::RAW_W+ibcs_pkg::GAIN_W:8])) +
               (ibcs_pkg::BIAS_W+2)'(temp_bias_r);
    temp_res = ibcs_pkg::sat_out(ibcs_pkg::SAT_W'(sum));
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && in_word_r.op == ibcs_pkg::OP_MEAS) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_word_r.op == ibcs_pkg::OP_MEAS) begin
      out_word_r.accel_x_out   <= axis_res[0];
      out_word_r.accel_y_out   <= axis_res[1];
      out_word_r.accel_z_out   <= axis_res[2];
      out_word_r.temp_out_q    <= temp_res;
      out_word_r.gyro_x_out    <= axis_res[3];
      out_word_r.gyro_y_out    <= axis_res[4];
      out_word_r.gyro_z_out    <= axis_res[5];
      out_word_r.is_calibrated <= cal_done_r;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.accel_x_out   = out_word_r.accel_x_out;
  assign out_ch.accel_y_out   = out_word_r.accel_y_out;
  assign out_ch.accel_z_out   = out_word_r.accel_z_out;
  assign out_ch.temp_out_q    = out_word_r.temp_out_q;
  assign out_ch.gyro_x_out    = out_word_r.gyro_x_out;
  assign out_ch.gyro_y_out    = out_word_r.gyro_y_out;
  assign out_ch.gyro_z_out    = out_word_r.gyro_z_out;
  assign out_ch.is_calibrated = out_word_r.is_calibrated;

endmodule
